// ===== src/pfc_pkg.sv =====
// Package for the probe frame checker: shared types, frame layout constants
// and the byte-wide CRC-32C step. Used by every module in src.
package pfc_pkg;

  localparam int unsigned FrameBytes = 28;
  localparam int unsigned CountW     = 5;
  localparam int unsigned NodePos    = 8;
  localparam int unsigned SeqPos     = 12;
  localparam int unsigned StampPos   = 16;
  localparam int unsigned CheckPos   = 24;

  localparam logic [7:0]  MagicN     = 8'h4E;
  localparam logic [7:0]  MagicP     = 8'h50;
  localparam logic [7:0]  MagicR     = 8'h52;
  localparam logic [7:0]  MagicB     = 8'h42;
  localparam logic [7:0]  SizeLo     = 8'(FrameBytes);
  localparam logic [7:0]  SizeHi     = 8'(FrameBytes >> 8);
  localparam logic [31:0] Crc32cPoly = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [7:0]  VersionRst = 8'd1;

  // One input word: a frame byte and its end-of-frame flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic        accepted;
    logic [31:0] node_id;
    logic [31:0] sequence_number;
    logic [63:0] timestamp_us;
  } res_word_t;

  // Reflected CRC-32C over one byte, bit at a time.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? Crc32cPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== src/probe_frame_checker_unit.sv =====
// Top level of the probe frame checker: input register, frame state and
// result register. Depends on pfc_pkg, pfc_in_reg, pfc_frame_check, pfc_out_reg.
//
//   Channel | Direction | Handshake          | Word
//   in_     | input     | in_valid/in_stall  | data_byte, last_byte
//   out_    | output    | out_valid/out_stall| accepted, node_id, sequence_number,
//           |           |                    | timestamp_us
//   cfg_    | input     | cfg_valid/cfg_ready| expected_version (8 bits)
//
// A byte is taken every cycle unless in_stall is high. Each word passes the input
// register and then the frame state logic. A frame's result is loaded into the
// result register at the same edge at which its last byte leaves the input
// register, and out_valid rises with it. The byte-wide CRC-32C step and the
// 32-bit check compare set the path between the two registers.
// Reset (rst_n low, synchronous) empties both registers, clears the frame state
// and sets the version to 1. While a result waits under out_stall, bytes that do
// not end a frame still go on; only a word that ends a frame waits, and then
// in_stall rises.
module probe_frame_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [31:0] out_node_id,
  output logic [31:0] out_sequence_number,
  output logic [63:0] out_timestamp_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_expected_version
);
  import pfc_pkg::*;

  logic      [7:0] version_r;
  in_word_t        in_word;
  in_word_t        s1_word;
  logic            s1_valid;
  logic            advance;
  logic            res_load;
  logic            res_ready;
  res_word_t       res_word;
  res_word_t       out_word;

  // The version register takes a write on any cycle; the user must write it only
  // while the block holds no frame in flight, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VersionRst;
    end else if (cfg_valid && cfg_ready) begin
      version_r <= cfg_expected_version;
    end
  end

  assign in_word.data_byte = in_data_byte;
  assign in_word.last_byte = in_last_byte;

  pfc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  pfc_frame_check u_frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .expected_version (version_r),
    .s1_valid         (s1_valid),
    .s1_word          (s1_word),
    .res_ready        (res_ready),
    .advance          (advance),
    .res_load         (res_load),
    .res_word         (res_word)
  );

  pfc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res_word  (res_word),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_accepted        = out_word.accepted;
  assign out_node_id         = out_word.node_id;
  assign out_sequence_number = out_word.sequence_number;
  assign out_timestamp_us    = out_word.timestamp_us;

  // The input side stalls only with a held word that cannot move on.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && s1_word.last_byte)
    else $error("in_stall raised without a blocked end-of-frame word");

  // An end-of-frame word that leaves the input register shows up as a result.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid)
    else $error("frame end did not produce a result");

  // A rejected frame reports all-zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |->
      out_node_id == 32'd0 && out_sequence_number == 32'd0 &&
      out_timestamp_us == 64'd0)
    else $error("rejected frame carries nonzero fields");

  // A new result never overwrites one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !res_load)
    else $error("result register overwritten while stalled");

endmodule

// ===== src/pfc_in_reg.sv =====
// Input register of the probe frame checker: holds one word and drives stall.
// Depends on pfc_pkg for the input word type.
module pfc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfc_pkg::in_word_t in_word,
  input  logic              advance,
  output logic              s1_valid,
  output pfc_pkg::in_word_t s1_word
);
  import pfc_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  in_word_t s1_word_r;
  logic     load;

  // The held word blocks new input only when it cannot move on this cycle.
  assign in_stall = s1_valid_r & ~advance;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_word_r <= in_word;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_word_r;

endmodule

// ===== src/pfc_frame_check.sv =====
// Frame state of the probe frame checker: byte count, header check, field
// assembly and running CRC-32C. Depends on pfc_pkg.
module pfc_frame_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         expected_version,
  input  logic               s1_valid,
  input  pfc_pkg::in_word_t  s1_word,
  input  logic               res_ready,
  output logic               advance,
  output logic               res_load,
  output pfc_pkg::res_word_t res_word
);
  import pfc_pkg::*;

  logic [CountW-1:0] byte_count_r, byte_count_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic              header_good_r, header_good_nxt;
  logic [31:0]       node_r, node_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic [63:0]       stamp_r, stamp_nxt;
  logic [31:0]       check_r, check_nxt;
  logic [7:0]        want;
  logic              check_hdr;
  logic [7:0]        b;
  logic              take;
  logic              ok;

  assign b = s1_word.data_byte;

  // Only the last byte of a frame needs room in the result register.
  assign advance  = s1_valid & (~s1_word.last_byte | res_ready);
  assign res_load = advance & s1_word.last_byte;
  assign take     = byte_count_r < CountW'(FrameBytes);

  always_comb begin
    want      = 8'd0;
    check_hdr = 1'b1;
    case (byte_count_r)
      5'd0:    want = MagicN;
      5'd1:    want = MagicP;
      5'd2:    want = MagicR;
      5'd3:    want = MagicB;
      5'd4:    want = expected_version;
      5'd5:    want = 8'd0;
      5'd6:    want = SizeLo;
      5'd7:    want = SizeHi;
      default: check_hdr = 1'b0;
    endcase
  end

  always_comb begin
    header_good_nxt = header_good_r;
    node_nxt        = node_r;
    seq_nxt         = seq_r;
    stamp_nxt       = stamp_r;
    check_nxt       = check_r;
    crc_nxt         = crc_r;
    byte_count_nxt  = byte_count_r;
    if (take) begin
      if (check_hdr && b != want) begin
        header_good_nxt = 1'b0;
      end
      if (byte_count_r inside {[NodePos:SeqPos-1]}) begin
        node_nxt[8*byte_count_r[1:0] +: 8] = b;
      end else if (byte_count_r inside {[SeqPos:StampPos-1]}) begin
        seq_nxt[8*byte_count_r[1:0] +: 8] = b;
      end else if (byte_count_r inside {[StampPos:CheckPos-1]}) begin
        stamp_nxt[8*byte_count_r[2:0] +: 8] = b;
      end else if (byte_count_r >= CountW'(CheckPos)) begin
        check_nxt[8*byte_count_r[1:0] +: 8] = b;
      end
      // The stored check bytes enter the CRC as zero.
      crc_nxt = crc32c_byte(crc_r, (byte_count_r >= CountW'(CheckPos)) ? 8'd0 : b);
    end
    if (byte_count_r < CountW'(FrameBytes + 1)) begin
      byte_count_nxt = byte_count_r + 1'b1;
    end
  end

  assign ok = (byte_count_nxt == CountW'(FrameBytes)) & header_good_nxt &
              ((crc_nxt ^ CrcInit) == check_nxt);

  always_comb begin
    res_word.accepted        = ok;
    res_word.node_id         = ok ? node_nxt  : 32'd0;
    res_word.sequence_number = ok ? seq_nxt   : 32'd0;
    res_word.timestamp_us    = ok ? stamp_nxt : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      byte_count_r  <= '0;
      crc_r         <= CrcInit;
      header_good_r <= 1'b1;
      node_r        <= '0;
      seq_r         <= '0;
      stamp_r       <= '0;
      check_r       <= '0;
    end else if (advance) begin
      byte_count_r  <= byte_count_nxt;
      crc_r         <= crc_nxt;
      header_good_r <= header_good_nxt;
      node_r        <= node_nxt;
      seq_r         <= seq_nxt;
      stamp_r       <= stamp_nxt;
      check_r       <= check_nxt;
    end
  end

endmodule

// ===== src/pfc_out_reg.sv =====
// Result register of the probe frame checker with its valid flag.
// Depends on pfc_pkg for the result word type.
module pfc_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_load,
  input  pfc_pkg::res_word_t res_word,
  output logic               res_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output pfc_pkg::res_word_t out_word
);
  import pfc_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  res_word_t out_word_r;

  assign res_ready = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== test/probe_frame_checker_unit_test.sv =====
// Self-checking testbench for probe_frame_checker_unit: random and directed probe frames,
// checked against a cycle-free model of the frame checker kept alongside the driver.
// Depends on pfc_pkg and the probe_frame_checker_unit RTL only.
module probe_frame_checker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  // Payload fill for generated frames: random content or the two extremes.
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  localparam int CycleLimit  = 200_000;
  localparam int LongHold    = 400;
  localparam int SettleWait  = 4;
  localparam int IdlePercent = 22;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [31:0] out_node_id;
  logic [31:0] out_sequence_number;
  logic [63:0] out_timestamp_us;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_expected_version = 8'h00;

  probe_frame_checker_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_node_id         (out_node_id),
    .out_sequence_number (out_sequence_number),
    .out_timestamp_us    (out_timestamp_us),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_expected_version(cfg_expected_version)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Words waiting to be offered, and the verdicts the block owes us, oldest first.
  in_word_t  byte_q[$];
  res_word_t verdict_q[$];
  logic [7:0] draft[$];

  // Model of the frame being assembled inside the block.
  logic [7:0]        version_model = VersionRst;
  logic [CountW-1:0] frame_pos;
  logic [31:0]       crc_run;
  logic              header_ok;
  logic [31:0]       node_acc;
  logic [31:0]       seq_acc;
  logic [63:0]       stamp_acc;
  logic [31:0]       check_acc;

  int  words_queued  = 0;
  int  words_taken   = 0;
  int  frames_sent   = 0;
  int  results_seen  = 0;
  int  accepts_seen  = 0;
  int  error_cnt     = 0;
  int  cycle_cnt     = 0;
  int  hold_requests = 0;
  int  holds_served  = 0;
  int  hold_left     = 0;
  bit  gap_free      = 1'b0;
  logic [7:0] mid_version;

  // Reflected CRC-32C, one data bit per iteration.
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ Crc32cPoly;
      else r = r >> 1;
    end
    return r;
  endfunction

  task automatic clear_frame_model();
    frame_pos = '0;
    crc_run   = CrcInit;
    header_ok = 1'b1;
    node_acc  = '0;
    seq_acc   = '0;
    stamp_acc = '0;
    check_acc = '0;
  endtask

  // Advances the frame model by one accepted word. A word flagged as the last one
  // of its frame produces exactly one verdict; every other word produces none.
  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    logic [7:0] want;
    logic       checked;
    res_word_t  verdict;
    if (frame_pos < FrameBytes) begin
      checked = 1'b1;
      want    = 8'h00;
      case (frame_pos)
        0: want = MagicN;
        1: want = MagicP;
        2: want = MagicR;
        3: want = MagicB;
        4: want = version_model;
        5: want = 8'h00;
        6: want = SizeLo;
        7: want = SizeHi;
        default: checked = 1'b0;
      endcase
      if (checked && b != want) header_ok = 1'b0;
      if (frame_pos >= NodePos && frame_pos < SeqPos)
        node_acc[8*(frame_pos-NodePos) +: 8] = b;
      else if (frame_pos >= SeqPos && frame_pos < StampPos)
        seq_acc[8*(frame_pos-SeqPos) +: 8] = b;
      else if (frame_pos >= StampPos && frame_pos < CheckPos)
        stamp_acc[8*(frame_pos-StampPos) +: 8] = b;
      else if (frame_pos >= CheckPos)
        check_acc[8*(frame_pos-CheckPos) +: 8] = b;
      // The stored check bytes go through the CRC as zeros.
      crc_run = crc_step(crc_run, (frame_pos >= CheckPos) ? 8'h00 : b);
    end
    // The count stops one past the frame size, so any long frame stays long.
    if (frame_pos < FrameBytes + 1) frame_pos++;
    if (last) begin
      verdict.accepted        = frame_pos == FrameBytes && header_ok && ~crc_run == check_acc;
      verdict.node_id         = verdict.accepted ? node_acc : '0;
      verdict.sequence_number = verdict.accepted ? seq_acc : '0;
      verdict.timestamp_us    = verdict.accepted ? stamp_acc : '0;
      verdict_q.push_back(verdict);
      clear_frame_model();
    end
  endtask

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_result(input res_word_t got);
    res_word_t want;
    if (verdict_q.size() == 0) begin
      note_error($sformatf("unexpected result acc=%0b node=%h seq=%h stamp=%h",
                           got.accepted, got.node_id, got.sequence_number,
                           got.timestamp_us));
      return;
    end
    want = verdict_q.pop_front();
    results_seen++;
    if (got.accepted) accepts_seen++;
    if (got.accepted !== want.accepted || got.node_id !== want.node_id ||
        got.sequence_number !== want.sequence_number ||
        got.timestamp_us !== want.timestamp_us) begin
      note_error($sformatf("result %0d: expected acc=%0b node=%h seq=%h stamp=%h",
                           results_seen, want.accepted, want.node_id,
                           want.sequence_number, want.timestamp_us));
      if (error_cnt <= 10)
        $display("    got acc=%0b node=%h seq=%h stamp=%h", got.accepted, got.node_id,
                 got.sequence_number, got.timestamp_us);
    end
  endtask

  // Builds a well-formed 28-byte probe in draft, carrying the given version byte
  // and a correct little-endian CRC-32C in its last four bytes.
  task automatic draft_probe(input logic [7:0] ver, input fill_t fill);
    logic [31:0] crc;
    logic [7:0]  b;
    draft.delete();
    draft.push_back(MagicN);
    draft.push_back(MagicP);
    draft.push_back(MagicR);
    draft.push_back(MagicB);
    draft.push_back(ver);
    draft.push_back(8'h00);
    draft.push_back(SizeLo);
    draft.push_back(SizeHi);
    for (int i = NodePos; i < CheckPos; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      draft.push_back(b);
    end
    crc = CrcInit;
    foreach (draft[i]) crc = crc_step(crc, draft[i]);
    for (int i = 0; i < 4; i++) crc = crc_step(crc, 8'h00);
    crc = ~crc;
    for (int i = 0; i < 4; i++) draft.push_back(crc[8*i +: 8]);
  endtask

  task automatic cut_draft(input int keep);
    while (draft.size() > keep) void'(draft.pop_back());
  endtask

  // Queues the draft as words, with the end flag on its final byte only.
  task automatic send_draft();
    in_word_t w;
    foreach (draft[i]) begin
      w.data_byte = draft[i];
      w.last_byte = (i == draft.size() - 1);
      byte_q.push_back(w);
    end
    words_queued += draft.size();
    frames_sent++;
  endtask

  // Most frames are well formed with random content, so the CRC and payload paths
  // are really exercised; the rest are spoiled, short, long, of a foreign version,
  // or plain noise.
  task automatic random_frame(input logic [7:0] ver);
    int pick;
    pick = $urandom_range(0, 99);
    draft_probe(ver, FILL_RANDOM);
    if (pick < 64) begin
    end else if (pick < 74) begin
      draft[$urandom_range(0, FrameBytes - 1)] ^= 8'($urandom_range(1, 255));
    end else if (pick < 82) begin
      cut_draft($urandom_range(1, FrameBytes - 1));
    end else if (pick < 89) begin
      repeat ($urandom_range(1, 14)) draft.push_back(8'($urandom));
    end else if (pick < 95) begin
      draft_probe(ver ^ 8'($urandom_range(1, 255)), FILL_RANDOM);
    end else begin
      draft.delete();
      repeat ($urandom_range(1, 40)) draft.push_back(8'($urandom));
    end
    send_draft();
  endtask

  // Waits until every queued word has been taken and every verdict has come back,
  // then lets the pipeline settle, since trailing words make no result.
  task automatic drain_all();
    while (words_taken != words_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    @(posedge clk);
    cfg_valid            <= 1'b1;
    cfg_expected_version <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    version_model  = v;
  endtask

  task automatic random_phase(input logic [7:0] ver);
    int first_word;
    int first_frame;
    first_word  = words_queued;
    first_frame = frames_sent;
    while (words_queued - first_word < 150 || frames_sent - first_frame < 4)
      random_frame(ver);
    drain_all();
  endtask

  // Sender: a word stays on the bus, unchanged, for as long as it is stalled.
  // Otherwise the next queued word goes out unless this cycle is picked as a gap.
  always @(posedge clk) begin : drive_words
    in_word_t w;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        track_frame_byte(in_data_byte, in_last_byte);
        words_taken++;
      end
      if (in_valid && in_stall) begin
      end else if (byte_q.size() != 0 &&
                   (gap_free || $urandom_range(0, 99) >= IdlePercent)) begin
        w = byte_q.pop_front();
        in_valid     <= 1'b1;
        in_data_byte <= w.data_byte;
        in_last_byte <= w.last_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold: counts down on its own so the stall decision only has to
  // look at whether any of it is left.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      hold_left    <= LongHold;
      holds_served <= holds_served + 1;
    end
  end

  // Receiver: checks each result word taken at this edge, then picks the stall
  // for the next cycle.
  always @(posedge clk) begin : watch_results
    res_word_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.accepted        = out_accepted;
        got.node_id         = out_node_id;
        got.sequence_number = out_sequence_number;
        got.timestamp_us    = out_timestamp_us;
        check_result(got);
      end
      out_stall <= (hold_left != 0) ||
                   (!gap_free && $urandom_range(0, 99) < IdlePercent);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d verdicts outstanding",
               cycle_cnt, verdict_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clear_frame_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset version: payload extremes, a one-byte
    // frame, a frame one byte short, a long frame past the count's saturation,
    // and one broken field each in magic, version, reserved, size and CRC.
    draft_probe(VersionRst, FILL_ZERO);
    send_draft();
    draft_probe(VersionRst, FILL_ONES);
    send_draft();
    draft_probe(VersionRst, FILL_RANDOM);
    send_draft();
    draft_probe(VersionRst, FILL_RANDOM);
    cut_draft(1);
    send_draft();
    draft_probe(VersionRst, FILL_RANDOM);
    cut_draft(FrameBytes - 1);
    send_draft();
    draft_probe(VersionRst, FILL_ONES);
    repeat (12) draft.push_back(8'hFF);
    send_draft();
    draft_probe(VersionRst, FILL_RANDOM);
    draft[2] ^= 8'h80;
    send_draft();
    draft_probe(VersionRst ^ 8'h03, FILL_RANDOM);
    send_draft();
    draft_probe(VersionRst, FILL_RANDOM);
    draft[5] = 8'h80;
    send_draft();
    draft_probe(VersionRst, FILL_RANDOM);
    draft[7] = 8'h01;
    send_draft();
    draft_probe(VersionRst, FILL_RANDOM);
    draft[FrameBytes - 1] ^= 8'h01;
    send_draft();
    drain_all();

    // Random phases, each under its own version: the low extreme with random
    // gaps, the high extreme with one long result hold so the block backs up
    // into its input, a middle value with no gaps at all, then the reset value.
    write_version(8'h00);
    random_phase(8'h00);

    write_version(8'hFF);
    hold_requests++;
    random_phase(8'hFF);

    mid_version = 8'($urandom_range(2, 254));
    write_version(mid_version);
    gap_free = 1'b1;
    random_phase(mid_version);
    gap_free = 1'b0;

    write_version(VersionRst);
    random_phase(VersionRst);

    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0)
      note_error($sformatf("%0d expected results never arrived", verdict_q.size()));

    $display("Checked %0d results from %0d frames (%0d accepted, %0d rejected), %0d words.",
             results_seen, frames_sent, accepts_seen, results_seen - accepts_seen,
             words_taken);
    $display("Versions 01, 00, FF, %h and 01 again; one %0d-cycle result hold.",
             mid_version, LongHold);
    if (error_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
